// ----- sv/address_range_table_macros.svh -----
// Assertion macros shared by the checker files of the address range table.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ADDRESS_RANGE_TABLE_MACROS_SVH
`define ADDRESS_RANGE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ART_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/art_pkg.sv -----
// Shared types and constants for the address range table.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

    localparam int ART_TABLE_ENTRIES = 64;
    localparam int ART_DATA_W        = 64;

    typedef enum logic [1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load;   // capture the input beat, rewind the scan
        logic    wr;     // store the captured range at the fill count
        logic    rd;     // read the entry at the scan index and advance
        logic    resp;   // register a result beat
        t_status code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_lookup;
        logic full;
        logic idx_end;
        logic hit;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/art_ctrl.sv -----
// Controller state machine for the address range table.
// Depends on art_pkg; drives art_datapath through t_cmd and reads t_dp_status.
`timescale 1ns / 1ps
`default_nettype none

module art_ctrl
    import art_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.idx_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // lookup is decided in S_INSERT, the cycle after capture
        if (r_state == S_INSERT && i_stat.is_lookup) begin
            n_state = S_SCAN;
        end
    end

    always_comb begin
        o_cmd  = '{load: 1'b0, wr: 1'b0, rd: 1'b0, resp: 1'b0, code: STAT_INSERTED};
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_INSERT: begin
                if (i_stat.is_lookup) begin
                    // first read of the scan
                    o_cmd.rd = !i_stat.idx_end;
                end else begin
                    o_cmd.resp = 1'b1;
                    o_cmd.wr   = !i_stat.full;
                    o_cmd.code = i_stat.full ? STAT_FULL : STAT_INSERTED;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.resp = 1'b1;
                    o_cmd.code = STAT_FOUND;
                end else if (i_stat.idx_end) begin
                    o_cmd.resp = 1'b1;
                    o_cmd.code = STAT_NOT_FOUND;
                end else begin
                    o_cmd.rd = 1'b1;
                end
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/art_datapath.sv -----
// Datapath of the address range table: entry memory, fill count, scan index,
// range compare and result registers. Depends on art_pkg.
`timescale 1ns / 1ps
`default_nettype none

module art_datapath
    import art_pkg::*;
#(
    parameter int TABLE_ENTRIES = ART_TABLE_ENTRIES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_action,
    input  wire logic [ART_DATA_W-1:0] i_range_start,
    input  wire logic [ART_DATA_W-1:0] i_range_end,
    input  wire logic [ART_DATA_W-1:0] i_range_offset,
    input  wire logic [ART_DATA_W-1:0] i_range_inode,
    input  wire logic [ART_DATA_W-1:0] i_lookup_address,
    output t_dp_status                 o_stat,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [ART_DATA_W-1:0]      o_hit_start,
    output logic [ART_DATA_W-1:0]      o_hit_end,
    output logic [ART_DATA_W-1:0]      o_hit_offset,
    output logic [ART_DATA_W-1:0]      o_hit_inode
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = 4 * ART_DATA_W;

    logic [EW-1:0]         r_mem [TABLE_ENTRIES];
    logic [EW-1:0]         r_rd_data;
    logic [EW-1:0]         r_wr_data;
    logic                  r_action;
    logic [ART_DATA_W-1:0] r_addr;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic                  r_cmp_valid;

    logic                  r_valid;
    t_status               r_status;
    logic [EW-1:0]         r_hit;

    logic [ART_DATA_W-1:0] rd_start;
    logic [ART_DATA_W-1:0] rd_end;
    logic                  hit;

    // entry layout: start, end, offset, inode from high to low
    assign rd_start = r_rd_data[EW-1 -: ART_DATA_W];
    assign rd_end   = r_rd_data[EW-ART_DATA_W-1 -: ART_DATA_W];
    assign hit      = r_cmp_valid && (r_addr >= rd_start) && (r_addr < rd_end);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_addr    <= i_lookup_address;
            r_wr_data <= {i_range_start, i_range_end, i_range_offset, i_range_inode};
        end
        if (i_cmd.wr) begin
            r_mem[r_count[AW-1:0]] <= r_wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + CW'(1);
            end
            r_cmp_valid <= i_cmd.rd;
            r_valid     <= i_cmd.resp;
        end
    end

    // result payload; hit fields stay zero unless a match is reported
    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_status <= i_cmd.code;
            r_hit    <= (i_cmd.code == STAT_FOUND) ? r_rd_data : '0;
        end
    end

    assign o_stat.is_lookup = (r_action == ACT_LOOKUP);
    assign o_stat.full      = (r_count == CW'(TABLE_ENTRIES));
    assign o_stat.idx_end   = (r_idx == r_count);
    assign o_stat.hit       = hit;

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_hit_start  = r_hit[EW-1 -: ART_DATA_W];
    assign o_hit_end    = r_hit[EW-ART_DATA_W-1 -: ART_DATA_W];
    assign o_hit_offset = r_hit[2*ART_DATA_W-1 -: ART_DATA_W];
    assign o_hit_inode  = r_hit[ART_DATA_W-1:0];

endmodule

`default_nettype wire

// ----- sv/address_range_table.sv -----
// Channel    | Handshake        | Beat contents
// command    | start / busy     | i_action, i_range_*, i_lookup_address
// result     | o_valid (strobe) | o_status, o_hit_start/end/offset/inode
//
// An insert registers its result in S_INSERT, the state after start is taken. A
// lookup scans the stored ranges and reports the first match; a miss is reported
// once the scan index reaches the fill count. The single read port of the entry
// memory sets the scan pace: one stored range is read and compared per cycle, in
// insert order.
// Synchronous reset empties the table; no clearing pass is needed.
// The result strobe lasts one cycle and cannot be stalled.
// Top level: wires art_ctrl to art_datapath. Depends on art_pkg.
`timescale 1ns / 1ps
`default_nettype none

module address_range_table
    import art_pkg::*;
#(
    parameter int TABLE_ENTRIES = ART_TABLE_ENTRIES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_action,
    input  wire logic [ART_DATA_W-1:0] i_range_start,
    input  wire logic [ART_DATA_W-1:0] i_range_end,
    input  wire logic [ART_DATA_W-1:0] i_range_offset,
    input  wire logic [ART_DATA_W-1:0] i_range_inode,
    input  wire logic [ART_DATA_W-1:0] i_lookup_address,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [ART_DATA_W-1:0]      o_hit_start,
    output logic [ART_DATA_W-1:0]      o_hit_end,
    output logic [ART_DATA_W-1:0]      o_hit_offset,
    output logic [ART_DATA_W-1:0]      o_hit_inode
);

    t_cmd       cmd;
    t_dp_status dp_stat;

    art_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    art_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_range_start    (i_range_start),
        .i_range_end      (i_range_end),
        .i_range_offset   (i_range_offset),
        .i_range_inode    (i_range_inode),
        .i_lookup_address (i_lookup_address),
        .o_stat           (dp_stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_hit_start      (o_hit_start),
        .o_hit_end        (o_hit_end),
        .o_hit_offset     (o_hit_offset),
        .o_hit_inode      (o_hit_inode)
    );

endmodule

`default_nettype wire

// ----- sv/art_checker.sv -----
// Port-level checker for the address range table, bound to the top level.
// Depends on art_pkg and address_range_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "address_range_table_macros.svh"

module art_checker
    import art_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic                  o_valid,
    input  wire logic [1:0]            o_status,
    input  wire logic [ART_DATA_W-1:0] o_hit_start,
    input  wire logic [ART_DATA_W-1:0] o_hit_end,
    input  wire logic [ART_DATA_W-1:0] o_hit_offset,
    input  wire logic [ART_DATA_W-1:0] o_hit_inode
);

    `ART_ASSERT_NEXT(a_take_goes_busy, start && !busy, busy, "accepted beat did not raise busy")
    `ART_ASSERT_NOW(a_one_result, $fell(busy), o_valid, "busy dropped without a result beat")
    `ART_ASSERT_NOW(a_result_idle, o_valid, !busy, "result beat while still busy")
    `ART_ASSERT_NOW(a_miss_zero, o_valid && (o_status != STAT_FOUND), (o_hit_start == '0) && (o_hit_end == '0) && (o_hit_offset == '0) && (o_hit_inode == '0), "non-hit result carries range data")
    `ART_ASSERT_NOW(a_hit_nonempty, o_valid && (o_status == STAT_FOUND), o_hit_start < o_hit_end, "reported hit has an empty range")

endmodule

bind address_range_table art_checker u_art_checker (.*);

`default_nettype wire
